// ===== design/ifd_pkg.sv =====
// shared constants, codes and tag lookup for the field deframer
// no dependencies; used by identify_field_deframer_core and ifd_checker
`default_nettype none

package ifd_pkg;

    // parameter defaults
    localparam int unsigned LEN_BITS_DEF      = 16;
    localparam int unsigned MAX_VARINT_DEF    = 10;

    // fixed widths
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned CODE_W            = 3;
    localparam int unsigned ERR_W             = 3;
    localparam int unsigned CNT_W             = 4;
    localparam int unsigned PHASE_W           = 2;
    localparam int unsigned SHAMT_W           = 7;
    // seven payload bits shifted by at most 63
    localparam int unsigned VARINT_SPAN       = 71;
    // position from which a payload above one exceeds 64 bits
    localparam logic [CNT_W-1:0] LAST_GROUP_POS = 4'd9;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_TAG  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LEN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_LONG   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NONMIN = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LENOVF = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNC  = 3'd4;

    // field codes
    localparam logic [CODE_W-1:0] FC_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] FC_KEY       = 3'd1;
    localparam logic [CODE_W-1:0] FC_LISTEN    = 3'd2;
    localparam logic [CODE_W-1:0] FC_PROTOCOL  = 3'd3;
    localparam logic [CODE_W-1:0] FC_OBSERVED  = 3'd4;
    localparam logic [CODE_W-1:0] FC_PROTO_VER = 3'd5;
    localparam logic [CODE_W-1:0] FC_AGENT_VER = 3'd6;

    // single-byte tags of the known fields
    localparam logic [BYTE_W-1:0] TAG_KEY       = 8'h0A;
    localparam logic [BYTE_W-1:0] TAG_LISTEN    = 8'h12;
    localparam logic [BYTE_W-1:0] TAG_PROTOCOL  = 8'h1A;
    localparam logic [BYTE_W-1:0] TAG_OBSERVED  = 8'h22;
    localparam logic [BYTE_W-1:0] TAG_PROTO_VER = 8'h2A;
    localparam logic [BYTE_W-1:0] TAG_AGENT_VER = 8'h32;

    function automatic logic [CODE_W-1:0] tag_code(input logic [BYTE_W-1:0] tag);
        logic [CODE_W-1:0] code;
        begin
            case (tag)
                TAG_KEY:       code = FC_KEY;
                TAG_LISTEN:    code = FC_LISTEN;
                TAG_PROTOCOL:  code = FC_PROTOCOL;
                TAG_OBSERVED:  code = FC_OBSERVED;
                TAG_PROTO_VER: code = FC_PROTO_VER;
                TAG_AGENT_VER: code = FC_AGENT_VER;
                default:       code = FC_NONE;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/identify_field_deframer_core.sv =====
// each byte passes the input reg and then the result reg before its result is offered
// throughput: one message byte per cycle while out_stall is low; the per-byte varint / byte-counter
//   update is a loop on the parse state, so bytes stream back to back
// reset: rst_n is asynchronous, active low; it empties both registers and returns the parser
//   to waiting for a tag with no error held; parse state also returns there after each last byte
// top level of the tag/length/value field deframer; depends on ifd_pkg
`default_nettype none

module identify_field_deframer_core #(
    parameter int unsigned LEN_BITS         = ifd_pkg::LEN_BITS_DEF,
    parameter int unsigned MAX_VARINT_BYTES = ifd_pkg::MAX_VARINT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [ifd_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                         last_byte,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              data_valid,
    output logic [ifd_pkg::CODE_W-1:0]        field_code,
    output logic [ifd_pkg::BYTE_W-1:0]        data_out,
    output logic                              field_last,
    output logic                              field_empty,
    output logic                              message_done,
    output logic [ifd_pkg::ERR_W-1:0]         error_code
);

    localparam int unsigned VW = ifd_pkg::VARINT_SPAN;
    localparam logic [ifd_pkg::CNT_W:0] MAX_POS = (ifd_pkg::CNT_W + 1)'(MAX_VARINT_BYTES);

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                          in_full_reg;
    logic [ifd_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_last_reg;

    // ------------------------------------------------------------------
    // parse state
    // ------------------------------------------------------------------
    logic [ifd_pkg::PHASE_W-1:0]   phase_reg,  phase_next;
    logic [LEN_BITS-1:0]           acc_reg,    acc_next;     // low bits of the varint value
    logic                          ovf_reg,    ovf_next;     // varint bits at or above LEN_BITS
    logic [ifd_pkg::CNT_W-1:0]     count_reg,  count_next;   // varint byte position
    logic [ifd_pkg::CODE_W-1:0]    field_reg,  field_next;
    logic [LEN_BITS-1:0]           left_reg,   left_next;    // data bytes still owed
    logic [ifd_pkg::ERR_W-1:0]     err_reg,    err_next;     // sticky error

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                          out_valid_reg;
    logic                          dv_reg,  dv_next;
    logic [ifd_pkg::CODE_W-1:0]    fc_reg,  fc_next;
    logic [ifd_pkg::BYTE_W-1:0]    dout_reg, dout_next;
    logic                          fl_reg,  fl_next;
    logic                          fe_reg,  fe_next;
    logic                          done_reg;

    // the held byte moves on when the result register is free or being drained
    logic advance;
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;

    // ------------------------------------------------------------------
    // per-byte parse step
    // ------------------------------------------------------------------
    logic [6:0]                    part;
    logic                          more;
    logic [ifd_pkg::SHAMT_W-1:0]   shamt;
    logic [VW-1:0]                 shifted;
    logic [LEN_BITS-1:0]           acc_new;
    logic                          ovf_new;
    logic [ifd_pkg::PHASE_W-1:0]   ph_work;

    assign part    = in_byte_reg[6:0];
    assign more    = in_byte_reg[7];
    // seven bits per varint group
    assign shamt   = ifd_pkg::SHAMT_W'(count_reg) * ifd_pkg::SHAMT_W'(7);
    assign shifted = VW'(part) << shamt;
    assign acc_new = acc_reg | shifted[LEN_BITS-1:0];
    assign ovf_new = ovf_reg | (|shifted[VW-1:LEN_BITS]);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        count_next = count_reg;
        field_next = field_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        dv_next    = 1'b0;
        fc_next    = ifd_pkg::FC_NONE;
        dout_next  = '0;
        fl_next    = 1'b0;
        fe_next    = 1'b0;
        ph_work    = (phase_reg == ifd_pkg::PH_LEN) ? ifd_pkg::PH_LEN : ifd_pkg::PH_TAG;

        // after an error everything is discarded until the message end
        if (err_reg == ifd_pkg::ERR_NONE)
        begin
            if (phase_reg == ifd_pkg::PH_DATA && left_reg != '0)
            begin
                // payload byte; unknown fields are skipped silently
                if (field_reg != ifd_pkg::FC_NONE)
                begin
                    dv_next   = 1'b1;
                    fc_next   = field_reg;
                    dout_next = in_byte_reg;
                    fl_next   = (left_reg == LEN_BITS'(1));
                end
                left_next = left_reg - LEN_BITS'(1);
                if (left_reg == LEN_BITS'(1))
                begin
                    phase_next = ifd_pkg::PH_TAG;
                end
            end
            else
            begin
                phase_next = ph_work;
                if (count_reg >= ifd_pkg::LAST_GROUP_POS && part > 7'd1)
                begin
                    // would need more than 64 bits
                    err_next = ifd_pkg::ERR_LONG;
                end
                else if (more && ((ifd_pkg::CNT_W + 1)'(count_reg)
                                  + (ifd_pkg::CNT_W + 1)'(1)) >= MAX_POS)
                begin
                    err_next = ifd_pkg::ERR_LONG;
                end
                else if (!more && count_reg != '0 && in_byte_reg == '0)
                begin
                    // trailing zero group
                    err_next = ifd_pkg::ERR_NONMIN;
                end
                else if (more)
                begin
                    acc_next   = acc_new;
                    ovf_next   = ovf_new;
                    count_next = count_reg + ifd_pkg::CNT_W'(1);
                end
                else
                begin
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    count_next = '0;
                    if (ph_work == ifd_pkg::PH_TAG)
                    begin
                        // known tags are all single-byte; a longer tag is above 127
                        field_next = (count_reg == '0) ? ifd_pkg::tag_code(in_byte_reg)
                                                       : ifd_pkg::FC_NONE;
                        phase_next = ifd_pkg::PH_LEN;
                    end
                    else if (ovf_new)
                    begin
                        err_next = ifd_pkg::ERR_LENOVF;
                    end
                    else if (acc_new == '0)
                    begin
                        // empty known field gets a marker
                        if (field_reg != ifd_pkg::FC_NONE)
                        begin
                            fc_next = field_reg;
                            fl_next = 1'b1;
                            fe_next = 1'b1;
                        end
                        phase_next = ifd_pkg::PH_TAG;
                    end
                    else
                    begin
                        left_next  = acc_new;
                        phase_next = ifd_pkg::PH_DATA;
                    end
                end
            end

            // message ended mid-record
            if (in_last_reg && err_next == ifd_pkg::ERR_NONE &&
                !(phase_next == ifd_pkg::PH_TAG && count_next == '0))
            begin
                err_next = ifd_pkg::ERR_TRUNC;
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ifd_pkg::PH_TAG;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            field_reg     <= ifd_pkg::FC_NONE;
            left_reg      <= '0;
            err_reg       <= ifd_pkg::ERR_NONE;
        end
        else
        begin
            // input register fills on an input transfer, empties when it advances
            if (in_valid && !in_stall)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (in_last_reg)
                begin
                    // next message starts clean
                    phase_reg <= ifd_pkg::PH_TAG;
                    acc_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    count_reg <= '0;
                    field_reg <= ifd_pkg::FC_NONE;
                    left_reg  <= '0;
                    err_reg   <= ifd_pkg::ERR_NONE;
                end
                else
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    ovf_reg   <= ovf_next;
                    count_reg <= count_next;
                    field_reg <= field_next;
                    left_reg  <= left_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance)
        begin
            dv_reg   <= dv_next;
            fc_reg   <= fc_next;
            dout_reg <= dout_next;
            fl_reg   <= fl_next;
            fe_reg   <= fe_next;
            done_reg <= in_last_reg;
        end
    end

    // error_code is the sticky error after this byte
    logic [ifd_pkg::ERR_W-1:0] ecode_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ecode_reg <= err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_valid   = dv_reg;
    assign field_code   = fc_reg;
    assign data_out     = dout_reg;
    assign field_last   = fl_reg;
    assign field_empty  = fe_reg;
    assign message_done = done_reg;
    assign error_code   = ecode_reg;

endmodule

`default_nettype wire

// ===== design/ifd_checker.sv =====
// port-level checks for identify_field_deframer_core, attached with bind
// depends on ifd_pkg and the top level's port list
`default_nettype none

module ifd_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic                        data_valid,
    input wire logic [ifd_pkg::CODE_W-1:0]  field_code,
    input wire logic [ifd_pkg::BYTE_W-1:0]  data_out,
    input wire logic                        field_last,
    input wire logic                        field_empty,
    input wire logic                        message_done,
    input wire logic [ifd_pkg::ERR_W-1:0]   error_code
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(field_code)
            && $stable(error_code) && $stable(message_done))
        else $error("stalled result changed");

    // payload only goes out for a known field while no error is held,
    // except the byte that arrives on a truncating last byte
    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> field_code != ifd_pkg::FC_NONE
            && (error_code == ifd_pkg::ERR_NONE
                || (message_done && error_code == ifd_pkg::ERR_TRUNC)))
        else $error("payload byte without known field or with error");

    // empty marker is a last mark with no payload
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_empty |-> field_last && !data_valid
            && field_code != ifd_pkg::FC_NONE && error_code == ifd_pkg::ERR_NONE)
        else $error("malformed empty-field marker");

    // untagged results carry nothing
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_code == ifd_pkg::FC_NONE |-> !data_valid && !field_last
            && !field_empty && data_out == '0)
        else $error("result without field code carries data");

endmodule

bind identify_field_deframer_core ifd_checker u_ifd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_valid   (data_valid),
    .field_code   (field_code),
    .data_out     (data_out),
    .field_last   (field_last),
    .field_empty  (field_empty),
    .message_done (message_done),
    .error_code   (error_code)
);

`default_nettype wire

// ===== bench/ifd_test_pkg.sv =====
// result record and scoreboard for the field deframer bench
// depends on ifd_pkg for widths, phases, field and error codes
package ifd_test_pkg;
    import ifd_pkg::*;

    localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS_DEF) - 64'd1;

    typedef struct packed {
        logic              data_valid;
        logic [CODE_W-1:0] field_code;
        logic [BYTE_W-1:0] data_out;
        logic              field_last;
        logic              field_empty;
        logic              message_done;
        logic [ERR_W-1:0]  error_code;
    } deframe_result_t;

    class deframe_scoreboard;
        deframe_result_t owed_results[$];
        int unsigned     fail_count;

        // parse state of the predictor
        logic [PHASE_W-1:0]      parse_phase;
        logic [63:0]             varint_acc;
        logic [CNT_W-1:0]        varint_pos;
        logic [CODE_W-1:0]       open_field;
        logic [LEN_BITS_DEF-1:0] payload_left;
        logic [ERR_W-1:0]        held_error;

        function new();
            fail_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            parse_phase  = PH_TAG;
            varint_acc   = '0;
            varint_pos   = '0;
            open_field   = FC_NONE;
            payload_left = '0;
            held_error   = ERR_NONE;
        endfunction

        function logic [CODE_W-1:0] field_of_tag(logic [63:0] tag);
            case (tag)
                64'(TAG_KEY):       return FC_KEY;
                64'(TAG_LISTEN):    return FC_LISTEN;
                64'(TAG_PROTOCOL):  return FC_PROTOCOL;
                64'(TAG_OBSERVED):  return FC_OBSERVED;
                64'(TAG_PROTO_VER): return FC_PROTO_VER;
                64'(TAG_AGENT_VER): return FC_AGENT_VER;
                default:            return FC_NONE;
            endcase
        endfunction

        // one varint byte; 1 when the value is complete, errors land in held_error
        function bit take_varint(logic [7:0] b);
            int unsigned pos;
            logic [6:0]  part;
            logic        more;
            pos  = varint_pos;
            part = b[6:0];
            more = b[7];
            if (pos >= LAST_GROUP_POS && part > 7'd1) begin
                held_error = ERR_LONG;
                return 1'b0;
            end
            if (more && pos + 1 >= MAX_VARINT_DEF) begin
                held_error = ERR_LONG;
                return 1'b0;
            end
            if (!more && pos > 0 && b == 8'h00) begin
                held_error = ERR_NONMIN;
                return 1'b0;
            end
            varint_acc |= {57'd0, part} << (7 * pos);
            if (more) begin
                varint_pos = CNT_W'(pos + 1);
                return 1'b0;
            end
            varint_pos = '0;
            return 1'b1;
        endfunction

        // predict the result of one accepted byte
        function void note_byte(logic [7:0] b, logic is_last);
            deframe_result_t r;
            logic [63:0]     value;
            r = '0;
            if (held_error == ERR_NONE) begin
                if (parse_phase == PH_DATA && payload_left != 0) begin
                    if (open_field != FC_NONE) begin
                        r.data_valid = 1'b1;
                        r.field_code = open_field;
                        r.data_out   = b;
                        r.field_last = (payload_left == 1);
                    end
                    payload_left = payload_left - 1'b1;
                    if (payload_left == 0)
                        parse_phase = PH_TAG;
                end
                else begin
                    if (parse_phase != PH_LEN)
                        parse_phase = PH_TAG;
                    if (take_varint(b)) begin
                        value      = varint_acc;
                        varint_acc = '0;
                        if (parse_phase == PH_TAG) begin
                            open_field  = field_of_tag(value);
                            parse_phase = PH_LEN;
                        end
                        else if (value > LEN_MAX) begin
                            held_error = ERR_LENOVF;
                        end
                        else if (value == 0) begin
                            if (open_field != FC_NONE) begin
                                r.field_code  = open_field;
                                r.field_last  = 1'b1;
                                r.field_empty = 1'b1;
                            end
                            parse_phase = PH_TAG;
                        end
                        else begin
                            payload_left = value[LEN_BITS_DEF-1:0];
                            parse_phase  = PH_DATA;
                        end
                    end
                end
                if (is_last && held_error == ERR_NONE &&
                    !(parse_phase == PH_TAG && varint_pos == 0))
                    held_error = ERR_TRUNC;
            end
            r.message_done = is_last;
            r.error_code   = held_error;
            owed_results.push_back(r);
            if (is_last)
                clear_state();
        endfunction

        function int unsigned field_differs(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(deframe_result_t got);
            deframe_result_t want;
            int unsigned     bad;
            if (owed_results.size() == 0) begin
                $display("%0t: result arrived with none outstanding", $time);
                fail_count++;
                return;
            end
            want = owed_results.pop_front();
            bad  = field_differs("data_valid", want.data_valid, got.data_valid);
            bad += field_differs("field_code", want.field_code, got.field_code);
            bad += field_differs("data_out", want.data_out, got.data_out);
            bad += field_differs("field_last", want.field_last, got.field_last);
            bad += field_differs("field_empty", want.field_empty, got.field_empty);
            bad += field_differs("message_done", want.message_done, got.message_done);
            bad += field_differs("error_code", want.error_code, got.error_code);
            if (bad != 0)
                fail_count++;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // failures so far, counting results that never came
        function int unsigned failures();
            if (owed_results.size() != 0)
                $display("%0t: %0d results never arrived", $time, owed_results.size());
            return fail_count + owed_results.size();
        endfunction
    endclass

endpackage

// ===== bench/identify_field_deframer_core_test.sv =====
// self-checking bench for identify_field_deframer_core: directed frames, then random
// well-formed and broken tag/length/value messages; depends on ifd_pkg and ifd_test_pkg
module identify_field_deframer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ifd_pkg::*;
    import ifd_test_pkg::*;

    // random bytes to send after the directed frames
    localparam int unsigned RANDOM_BYTES = 1100;
    // from here on neither side idles
    localparam int unsigned QUIET_FROM   = 940;
    // cycles to watch for stray results once everything has arrived
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] data_byte    = '0;
    logic              last_byte    = 1'b0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic              data_valid;
    logic [CODE_W-1:0] field_code;
    logic [BYTE_W-1:0] data_out;
    logic              field_last;
    logic              field_empty;
    logic              message_done;
    logic [ERR_W-1:0]  error_code;

    deframe_scoreboard sb = new();

    // message under construction, sent as one frame
    logic [7:0]  frame_bytes[$];
    logic [7:0]  known_tags[6] = '{TAG_KEY, TAG_LISTEN, TAG_PROTOCOL,
                                   TAG_OBSERVED, TAG_PROTO_VER, TAG_AGENT_VER};
    // chance in percent of an idle burst before an input transfer
    int unsigned in_gap_pct     = 0;
    bit          quiet          = 1'b0;
    int unsigned cycle_count    = 0;

    identify_field_deframer_core #(
        .LEN_BITS         (LEN_BITS_DEF),
        .MAX_VARINT_BYTES (MAX_VARINT_DEF)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_valid   (data_valid),
        .field_code   (field_code),
        .data_out     (data_out),
        .field_last   (field_last),
        .field_empty  (field_empty),
        .message_done (message_done),
        .error_code   (error_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("identify_field_deframer_core_test: FAIL");
        $finish;
    end

    // every result transfer is checked against the oldest prediction;
    // sampled in the active region, so these are the pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({data_valid, field_code, data_out, field_last,
                             field_empty, message_done, error_code});
    end

    // result side back-pressure: random bursts of stall, with stalling switched on or off
    // for each stretch of the loop and none at all once quiet
    initial
    begin : result_stall
        int unsigned stretch_left;
        bit          stall_on;
        stretch_left = 0;
        stall_on     = 1'b1;
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                stall_on     = $urandom_range(0, 2) != 0;
                stretch_left = 64;
            end
            stretch_left--;
            if (!quiet && stall_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // minimal little-endian base-128 encoding
    function automatic void put_varint(input logic [63:0] value);
        logic [7:0] b;
        do
        begin
            b     = {1'b0, value[6:0]};
            value = value >> 7;
            if (value != 0)
                b[7] = 1'b1;
            frame_bytes.push_back(b);
        end
        while (value != 0);
    endfunction

    // same value with pad extra groups, the final one zero (non-minimal)
    function automatic void put_padded_varint(input logic [63:0] value, input int unsigned pad);
        put_varint(value);
        frame_bytes[frame_bytes.size() - 1] = frame_bytes[frame_bytes.size() - 1] | 8'h80;
        repeat (pad - 1) frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h00);
    endfunction

    function automatic void put_record(input logic [63:0] tag, input logic [63:0] len);
        put_varint(tag);
        put_varint(len);
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // mostly known tags, else small or wide random values
    function automatic logic [63:0] pick_tag();
        if ($urandom_range(0, 3) != 0)
            return 64'(known_tags[$urandom_range(0, 5)]);
        if ($urandom_range(0, 1) != 0)
            return 64'($urandom_range(0, 127));
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    // lengths are mostly short; a few need a two-byte varint
    function automatic logic [63:0] pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 64'd0;
        if (roll < 85)
            return 64'($urandom_range(1, 6));
        if (roll < 97)
            return 64'($urandom_range(7, 40));
        return 64'($urandom_range(128, 300));
    endfunction

    function automatic void build_good_frame();
        repeat ($urandom_range(1, 4)) put_record(pick_tag(), pick_len());
    endfunction

    // one byte transfer, optionally after an idle burst; valid stays high on return
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_byte(b, is_last);
    endtask

    // send the frame under construction, flagging its final byte
    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    // hold the input off until every predicted result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned kind;
        bit          drained_mid;
        random_sent = 0;
        drained_mid = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every known field once: empty markers, data at both byte extremes
        in_gap_pct  = 30;
        frame_bytes = '{TAG_KEY, 8'h00, TAG_LISTEN, 8'h01, 8'hFF, TAG_PROTOCOL, 8'h00,
                        TAG_OBSERVED, 8'h00, TAG_PROTO_VER, 8'h00, TAG_AGENT_VER,
                        8'h01, 8'h00};
        send_frame();
        // unknown field of zero length, then a tag varint ending in a zero group
        frame_bytes = '{8'h08, 8'h00, 8'h80, 8'h00};
        send_frame();
        // message ends inside data; the payload byte still goes out
        frame_bytes = '{TAG_OBSERVED, 8'h02, 8'h41};
        send_frame();
        // tenth varint group carries more than one bit
        repeat (9) frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h02);
        send_frame();
        // length beyond the counter range
        frame_bytes = '{TAG_KEY, 8'hFF, 8'hFF, 8'h04};
        send_frame();
        wait_for_results();

        // random messages: mostly well formed, the rest broken in one way each
        while (random_sent < RANDOM_BYTES)
        begin
            quiet      = random_sent >= QUIET_FROM;
            in_gap_pct = quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : 30);
            if ($urandom_range(0, 99) < 65)
            begin
                build_good_frame();
            end
            else
            begin
                kind = $urandom_range(0, 5);
                // up to two good records ahead of the fault
                if (kind != 0 && kind != 4)
                    repeat ($urandom_range(0, 2)) put_record(pick_tag(), pick_len());
                case (kind)
                    0:
                    begin
                        // cut short anywhere: inside a varint, after a length, in data
                        build_good_frame();
                        while (frame_bytes.size() > $urandom_range(1, frame_bytes.size() - 1))
                            void'(frame_bytes.pop_back());
                    end
                    1:
                    begin
                        if ($urandom_range(0, 1) != 0)
                        begin
                            put_padded_varint(pick_tag(), $urandom_range(1, 3));
                        end
                        else
                        begin
                            put_varint(pick_tag());
                            put_padded_varint(pick_len(), $urandom_range(1, 3));
                        end
                    end
                    2:
                    begin
                        // over-long varint, in tag or length position
                        if ($urandom_range(0, 1) != 0)
                            put_varint(pick_tag());
                        if ($urandom_range(0, 1) != 0)
                        begin
                            repeat (9) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                            frame_bytes.push_back({1'($urandom_range(0, 1)),
                                                   7'($urandom_range(2, 127))});
                        end
                        else
                        begin
                            repeat ($urandom_range(10, 12))
                                frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                        end
                    end
                    3:
                    begin
                        put_varint(pick_tag());
                        case ($urandom_range(0, 2))
                            0:       put_varint(LEN_MAX + 64'd1 + 64'($urandom_range(0, 3)));
                            1:       put_varint({$urandom, $urandom} | (LEN_MAX + 64'd1));
                            default: put_varint((LEN_MAX + 64'd1) << $urandom_range(0, 47));
                        endcase
                    end
                    4:
                    begin
                        // raw noise, handled below
                    end
                    default:
                    begin
                        // top of the length range, message ends with data owed
                        put_varint(pick_tag());
                        put_varint(LEN_MAX - 64'($urandom_range(0, 1)));
                        repeat ($urandom_range(1, 5))
                            frame_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
                // trailing bytes are discarded once an error is held
                if (kind != 0)
                    repeat (kind == 4 ? $urandom_range(1, 12) : $urandom_range(0, 6))
                        frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (frame_bytes.size() == 0)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            random_sent += frame_bytes.size();
            send_frame();
            // sender pause halfway through with the block fully drained
            if (!drained_mid && random_sent >= RANDOM_BYTES / 2)
            begin
                wait_for_results();
                drained_mid = 1'b1;
            end
        end

        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (sb.failures() == 0)
            $display("identify_field_deframer_core_test: PASS");
        else
            $display("identify_field_deframer_core_test: FAIL");
        $finish;
    end

endmodule
